FILE: rtl/core/segint_pkg.sv
// Shared types and constants of the segment intersection block.
package segint_pkg;

   localparam int COORD_WIDTH = 32;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_end_x;
      coord_type second_end_y;
   } req_type;

   typedef struct packed {
      logic      hit;
      logic      point_valid;
      coord_type cross_x;
      coord_type cross_y;
   } rsp_type;

endpackage

FILE: rtl/core/segment_intersection_2d_top.sv
// Pipelined intersection of two 2D segments in signed Q16.16 fixed point.
//
// The req_ channel carries two segments as four endpoints. The rsp_ channel
// returns one result per request: the crossing point of the two carrying
// lines, rounded to nearest and saturated, a flag that the lines are not
// parallel, and a hit flag when the point lies strictly inside both segments.
// A request transfer happens when req_valid is high and req_stall is low; a
// result transfer happens when rsp_valid is high and rsp_stall is low.
// One request can be taken in every cycle in which req_stall is low. The
// pipeline length is set mostly by the restoring divider, which settles one
// quotient bit per stage for each coordinate.
// Every stage carries a valid bit and holds while the stage after it is
// full and stalled, so bubbles close up and nothing is lost or repeated.
// req_stall rises only when the whole pipeline is full and rsp_stall is high.
// Synchronous reset empties the pipeline; no result is pending after it.
module segment_intersection_2d_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  segint_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output segint_pkg::rsp_type rsp_data
);

   localparam int W    = segint_pkg::COORD_WIDTH;
   localparam int DFW  = W + 1;
   localparam int PW   = 2 * W + 2;
   localparam int PV   = PW + 1;
   localparam int NUMW = 2 * W + 3;
   localparam int LOW  = W + 2;
   localparam int HIW  = NUMW - LOW;
   localparam int LPW  = DFW + LOW + 1;
   localparam int HPW  = DFW + HIW;
   localparam int NW   = 3 * W + 4;
   localparam int DW   = NUMW;
   localparam int QW   = W + 2;
   localparam int SW   = W + 3;
   localparam int RDW  = DW + 1;

   typedef logic signed [DFW-1:0] diff_type;

   typedef struct packed {
      segint_pkg::req_type pts;
      diff_type            dx1;
      diff_type            dy1;
      diff_type            dx2;
      diff_type            dy2;
      diff_type            rx;
      diff_type            ry;
   } a_type;

   typedef struct packed {
      segint_pkg::req_type   pts;
      diff_type              dx1;
      diff_type              dy1;
      diff_type              dx2;
      logic                  v1;
      logic                  v2;
      logic signed [PW-1:0]  p1;
      logic signed [PW-1:0]  p2;
      logic signed [PW-1:0]  p3;
      logic signed [PW-1:0]  p4;
   } b_type;

   typedef struct packed {
      segint_pkg::req_type    pts;
      diff_type               dx1;
      diff_type               dy1;
      logic                   v1;
      logic                   v2;
      logic signed [NUMW-1:0] den;
      logic signed [NUMW-1:0] num;
      logic signed [PV-1:0]   nvert;
      diff_type               dvert;
   } c_type;

   typedef struct packed {
      segint_pkg::req_type    pts;
      logic                   v1;
      logic                   v2;
      logic                   bad;
      logic signed [NUMW-1:0] den;
      logic signed [PV-1:0]   nvert;
      diff_type               dvert;
      logic signed [LPW-1:0]  lx;
      logic signed [LPW-1:0]  ly;
      logic signed [HPW-1:0]  hx;
      logic signed [HPW-1:0]  hy;
   } d_type;

   typedef struct packed {
      segint_pkg::req_type   pts;
      logic                  v1;
      logic                  v2;
      logic                  bad;
      logic signed [NW-1:0]  nx;
      logic signed [NW-1:0]  ny;
      logic signed [DW-1:0]  ddx;
      logic signed [DW-1:0]  ddy;
      segint_pkg::coord_type base_x;
      segint_pkg::coord_type base_y;
   } e_type;

   typedef struct packed {
      segint_pkg::req_type   pts;
      logic                  v1;
      logic                  v2;
      logic                  bad;
      logic [NW-1:0]         rem_x;
      logic [NW-1:0]         rem_y;
      logic [DW-1:0]         dm_x;
      logic [DW-1:0]         dm_y;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ovf_x;
      logic                  ovf_y;
      logic [W:0]            q_x;
      logic [W:0]            q_y;
      segint_pkg::coord_type base_x;
      segint_pkg::coord_type base_y;
   } div_type;

   typedef struct packed {
      segint_pkg::req_type   pts;
      logic                  v1;
      logic                  v2;
      logic                  bad;
      logic [QW-1:0]         q_x;
      logic [QW-1:0]         q_y;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ovf_x;
      logic                  ovf_y;
      segint_pkg::coord_type base_x;
      segint_pkg::coord_type base_y;
   } r_type;

   typedef struct packed {
      segint_pkg::req_type   pts;
      logic                  v1;
      logic                  v2;
      logic                  bad;
      segint_pkg::coord_type cx;
      segint_pkg::coord_type cy;
   } s_type;

   function automatic logic inside_span(input segint_pkg::coord_type s,
                                        input segint_pkg::coord_type e,
                                        input segint_pkg::coord_type p);
      return ((s < e) && (p > s) && (p < e)) || ((s > e) && (p < s) && (p > e));
   endfunction

   function automatic segint_pkg::coord_type sat_sum(
         input segint_pkg::coord_type base, input logic [QW-1:0] q,
         input logic neg, input logic ovf);
      logic signed [SW-1:0]  qs;
      logic signed [SW-1:0]  val;
      segint_pkg::coord_type cmax;
      segint_pkg::coord_type cmin;
      qs   = $signed(SW'(q));
      val  = neg ? (SW'(base) - qs) : (SW'(base) + qs);
      cmin = {1'b1, {(W-1){1'b0}}};
      cmax = {1'b0, {(W-1){1'b1}}};
      if (ovf) begin
         return neg ? cmin : cmax;
      end else if ((val[SW-1:W-1] != {(SW-W+1){1'b0}})
                   && (val[SW-1:W-1] != {(SW-W+1){1'b1}})) begin
         return val[SW-1] ? cmin : cmax;
      end
      return val[W-1:0];
   endfunction

   a_type   a_ff, a_in;
   b_type   b_ff, b_in;
   c_type   c_ff, c_in;
   d_type   d_ff, d_in;
   e_type   e_ff, e_in;
   div_type f_ff, f_in;
   div_type g_ff, g_in;
   div_type div_ff [0:W];
   div_type div_in [0:W];
   r_type   r_ff, r_in;
   s_type   s_ff, s_in;
   segint_pkg::rsp_type rsp_ff, rsp_in;

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic f_valid_ff, g_valid_ff, r_valid_ff, s_valid_ff, rsp_valid_ff;
   logic [W:0] div_valid_ff;
   logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy, r_rdy, s_rdy, o_rdy;
   logic [W:0] div_rdy;

   // A stage takes new contents when it is empty or the next stage moves.
   assign o_rdy = !rsp_valid_ff || !rsp_stall;
   assign s_rdy = !s_valid_ff || o_rdy;
   assign r_rdy = !r_valid_ff || s_rdy;
   assign g_rdy = !g_valid_ff || div_rdy[0];
   assign f_rdy = !f_valid_ff || g_rdy;
   assign e_rdy = !e_valid_ff || f_rdy;
   assign d_rdy = !d_valid_ff || e_rdy;
   assign c_rdy = !c_valid_ff || d_rdy;
   assign b_rdy = !b_valid_ff || c_rdy;
   assign a_rdy = !a_valid_ff || b_rdy;

   assign req_stall = !a_rdy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      a_in.pts = req_data;
      a_in.dx1 = DFW'(req_data.first_end_x) - DFW'(req_data.first_start_x);
      a_in.dy1 = DFW'(req_data.first_end_y) - DFW'(req_data.first_start_y);
      a_in.dx2 = DFW'(req_data.second_end_x) - DFW'(req_data.second_start_x);
      a_in.dy2 = DFW'(req_data.second_end_y) - DFW'(req_data.second_start_y);
      a_in.rx  = DFW'(req_data.second_start_x) - DFW'(req_data.first_start_x);
      a_in.ry  = DFW'(req_data.second_start_y) - DFW'(req_data.first_start_y);
   end

   always_comb begin
      b_in.pts = a_ff.pts;
      b_in.dx1 = a_ff.dx1;
      b_in.dy1 = a_ff.dy1;
      b_in.dx2 = a_ff.dx2;
      b_in.v1  = (a_ff.dx1 == '0);
      b_in.v2  = (a_ff.dx2 == '0);
      b_in.p1  = PW'(a_ff.dx1) * PW'(a_ff.dy2);
      b_in.p2  = PW'(a_ff.dy1) * PW'(a_ff.dx2);
      b_in.p3  = PW'(a_ff.rx) * PW'(a_ff.dy2);
      if (a_ff.dx2 == '0) begin
         b_in.p4 = PW'(a_ff.dy1) * PW'(a_ff.rx);
      end else begin
         b_in.p4 = PW'(a_ff.ry) * PW'(a_ff.dx2);
      end
   end

   always_comb begin
      c_in.pts   = b_ff.pts;
      c_in.dx1   = b_ff.dx1;
      c_in.dy1   = b_ff.dy1;
      c_in.v1    = b_ff.v1;
      c_in.v2    = b_ff.v2;
      c_in.den   = NUMW'(b_ff.p1) - NUMW'(b_ff.p2);
      c_in.num   = NUMW'(b_ff.p3) - NUMW'(b_ff.p4);
      c_in.nvert = b_ff.v1 ? -PV'(b_ff.p3) : PV'(b_ff.p4);
      c_in.dvert = b_ff.v1 ? b_ff.dx2 : b_ff.dx1;
   end

   always_comb begin
      d_in.pts   = c_ff.pts;
      d_in.v1    = c_ff.v1;
      d_in.v2    = c_ff.v2;
      d_in.bad   = (c_ff.v1 && c_ff.v2) || (!c_ff.v1 && !c_ff.v2 && (c_ff.den == '0));
      d_in.den   = c_ff.den;
      d_in.nvert = c_ff.nvert;
      d_in.dvert = c_ff.dvert;
      d_in.lx    = LPW'(c_ff.dx1) * LPW'($signed({1'b0, c_ff.num[LOW-1:0]}));
      d_in.ly    = LPW'(c_ff.dy1) * LPW'($signed({1'b0, c_ff.num[LOW-1:0]}));
      d_in.hx    = HPW'(c_ff.dx1) * HPW'($signed(c_ff.num[NUMW-1:LOW]));
      d_in.hy    = HPW'(c_ff.dy1) * HPW'($signed(c_ff.num[NUMW-1:LOW]));
   end

   always_comb begin
      e_in.pts    = d_ff.pts;
      e_in.v1     = d_ff.v1;
      e_in.v2     = d_ff.v2;
      e_in.bad    = d_ff.bad;
      e_in.base_x = d_ff.v2 ? d_ff.pts.second_start_x : d_ff.pts.first_start_x;
      e_in.base_y = d_ff.v1 ? d_ff.pts.second_start_y : d_ff.pts.first_start_y;
      if (d_ff.v1 || d_ff.v2) begin
         e_in.nx  = '0;
         e_in.ny  = NW'(d_ff.nvert);
         e_in.ddx = DW'(d_ff.dvert);
         e_in.ddy = DW'(d_ff.dvert);
      end else begin
         e_in.nx  = (NW'(d_ff.hx) <<< LOW) + NW'(d_ff.lx);
         e_in.ny  = (NW'(d_ff.hy) <<< LOW) + NW'(d_ff.ly);
         e_in.ddx = d_ff.den;
         e_in.ddy = d_ff.den;
      end
   end

   always_comb begin
      f_in.pts    = e_ff.pts;
      f_in.v1     = e_ff.v1;
      f_in.v2     = e_ff.v2;
      f_in.bad    = e_ff.bad;
      f_in.rem_x  = e_ff.nx[NW-1] ? NW'(-e_ff.nx) : NW'(e_ff.nx);
      f_in.rem_y  = e_ff.ny[NW-1] ? NW'(-e_ff.ny) : NW'(e_ff.ny);
      f_in.dm_x   = e_ff.ddx[DW-1] ? DW'(-e_ff.ddx) : DW'(e_ff.ddx);
      f_in.dm_y   = e_ff.ddy[DW-1] ? DW'(-e_ff.ddy) : DW'(e_ff.ddy);
      f_in.neg_x  = e_ff.nx[NW-1] ^ e_ff.ddx[DW-1];
      f_in.neg_y  = e_ff.ny[NW-1] ^ e_ff.ddy[DW-1];
      f_in.ovf_x  = 1'b0;
      f_in.ovf_y  = 1'b0;
      f_in.q_x    = '0;
      f_in.q_y    = '0;
      f_in.base_x = e_ff.base_x;
      f_in.base_y = e_ff.base_y;
   end

   // A quotient of 2^(W+1) or more saturates whatever the base.
   always_comb begin
      g_in       = f_ff;
      g_in.ovf_x = (f_ff.rem_x >= {f_ff.dm_x, {(W+1){1'b0}}});
      g_in.ovf_y = (f_ff.rem_y >= {f_ff.dm_y, {(W+1){1'b0}}});
   end

   for (genvar j = 0; j <= W; j++) begin : g_div
      localparam int K = W - j;
      div_type src;
      logic [NW-1:0] sh_x;
      logic [NW-1:0] sh_y;

      if (j == 0) begin : g_first
         assign src = g_ff;
      end else begin : g_next
         assign src = div_ff[j-1];
      end

      if (j == W) begin : g_last_rdy
         assign div_rdy[j] = !div_valid_ff[j] || r_rdy;
      end else begin : g_mid_rdy
         assign div_rdy[j] = !div_valid_ff[j] || div_rdy[j+1];
      end

      assign sh_x = NW'(src.dm_x) << K;
      assign sh_y = NW'(src.dm_y) << K;

      always_comb begin
         div_in[j] = src;
         if (src.rem_x >= sh_x) begin
            div_in[j].rem_x  = src.rem_x - sh_x;
            div_in[j].q_x[K] = 1'b1;
         end
         if (src.rem_y >= sh_y) begin
            div_in[j].rem_y  = src.rem_y - sh_y;
            div_in[j].q_y[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j] <= 1'b0;
         end else if (div_rdy[j]) begin
            div_valid_ff[j] <= (j == 0) ? g_valid_ff : div_valid_ff[(j == 0) ? 0 : j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (div_rdy[j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // Round to nearest with ties away from zero on the magnitude.
   always_comb begin
      r_in.pts    = div_ff[W].pts;
      r_in.v1     = div_ff[W].v1;
      r_in.v2     = div_ff[W].v2;
      r_in.bad    = div_ff[W].bad;
      r_in.neg_x  = div_ff[W].neg_x;
      r_in.neg_y  = div_ff[W].neg_y;
      r_in.ovf_x  = div_ff[W].ovf_x;
      r_in.ovf_y  = div_ff[W].ovf_y;
      r_in.base_x = div_ff[W].base_x;
      r_in.base_y = div_ff[W].base_y;
      r_in.q_x    = QW'(div_ff[W].q_x)
                  + QW'({div_ff[W].rem_x[DW-1:0], 1'b0} >= RDW'(div_ff[W].dm_x));
      r_in.q_y    = QW'(div_ff[W].q_y)
                  + QW'({div_ff[W].rem_y[DW-1:0], 1'b0} >= RDW'(div_ff[W].dm_y));
   end

   always_comb begin
      s_in.pts = r_ff.pts;
      s_in.v1  = r_ff.v1;
      s_in.v2  = r_ff.v2;
      s_in.bad = r_ff.bad;
      if (r_ff.bad) begin
         s_in.cx = '0;
         s_in.cy = '0;
      end else begin
         s_in.cx = sat_sum(r_ff.base_x, r_ff.q_x, r_ff.neg_x, r_ff.ovf_x);
         s_in.cy = sat_sum(r_ff.base_y, r_ff.q_y, r_ff.neg_y, r_ff.ovf_y);
      end
   end

   always_comb begin
      logic in1;
      logic in2;
      in1 = s_ff.v1 ? inside_span(s_ff.pts.first_start_y, s_ff.pts.first_end_y, s_ff.cy)
                    : inside_span(s_ff.pts.first_start_x, s_ff.pts.first_end_x, s_ff.cx);
      in2 = s_ff.v2 ? inside_span(s_ff.pts.second_start_y, s_ff.pts.second_end_y, s_ff.cy)
                    : inside_span(s_ff.pts.second_start_x, s_ff.pts.second_end_x, s_ff.cx);
      rsp_in.hit         = !s_ff.bad && in1 && in2;
      rsp_in.point_valid = !s_ff.bad;
      rsp_in.cross_x     = s_ff.cx;
      rsp_in.cross_y     = s_ff.cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_rdy) a_valid_ff <= req_valid;
         if (b_rdy) b_valid_ff <= a_valid_ff;
         if (c_rdy) c_valid_ff <= b_valid_ff;
         if (d_rdy) d_valid_ff <= c_valid_ff;
         if (e_rdy) e_valid_ff <= d_valid_ff;
         if (f_rdy) f_valid_ff <= e_valid_ff;
         if (g_rdy) g_valid_ff <= f_valid_ff;
         if (r_rdy) r_valid_ff <= div_valid_ff[W];
         if (s_rdy) s_valid_ff <= r_valid_ff;
         if (o_rdy) rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy) a_ff <= a_in;
      if (b_rdy) b_ff <= b_in;
      if (c_rdy) c_ff <= c_in;
      if (d_rdy) d_ff <= d_in;
      if (e_rdy) e_ff <= e_in;
      if (f_rdy) f_ff <= f_in;
      if (g_rdy) g_ff <= g_in;
      if (r_rdy) r_ff <= r_in;
      if (s_rdy) s_ff <= s_in;
      if (o_rdy) rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_parallel_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.point_valid |->
         !rsp_data.hit && (rsp_data.cross_x == '0) && (rsp_data.cross_y == '0))
      else $error("Parallel result carries a point or a hit.");

   a_hit_needs_point : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.point_valid)
      else $error("Hit reported without a valid point.");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Pipeline not empty after reset.");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("Request stalled while the pipeline has room.");
`endif

endmodule

FILE: dv/segment_intersection_2d_top_tb.sv
// Self-checking testbench for the 2D segment intersection block.
module segment_intersection_2d_top_tb;

   typedef logic signed [255:0] wide_type;

   localparam int RANDOM_ITEMS = 1380;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LATENCY = segint_pkg::COORD_WIDTH + 11;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   segint_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   segint_pkg::rsp_type rsp_data;

   segint_pkg::req_type segment_q[$];
   segint_pkg::rsp_type crossing_q[$];
   int      total_items = 0;
   int      sent_count = 0;
   int      recv_count = 0;
   int      hit_count = 0;
   int      parallel_count = 0;
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      drain_at = 0;
   bit      drained = 1'b0;
   bit      req_taken = 1'b0;

   segment_intersection_2d_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic longint rounded_quotient(wide_type num, wide_type den);
      logic            negative;
      wide_type        abs_num;
      wide_type        abs_den;
      logic [255:0]    quo;
      logic [255:0]    remainder;
      longint          mag;
      negative = (num < 0) != (den < 0);
      abs_num = (num < 0) ? -num : num;
      abs_den = (den < 0) ? -den : den;
      if (abs_den == 0) begin
         return 0;
      end
      quo = $unsigned(abs_num) / $unsigned(abs_den);
      remainder = $unsigned(abs_num) % $unsigned(abs_den);
      if ((remainder << 1) >= $unsigned(abs_den)) begin
         quo = quo + 1;
      end
      if (quo >= (256'd1 << 62)) begin
         mag = longint'(1) << 62;
      end else begin
         mag = longint'(quo[63:0]);
      end
      return negative ? -mag : mag;
   endfunction

   function automatic segint_pkg::coord_type clamp_coord(longint v);
      longint lim;
      lim = longint'(1) << (segint_pkg::COORD_WIDTH - 1);
      if (v > lim - 1) begin
         return segint_pkg::coord_type'(lim - 1);
      end
      if (v < -lim) begin
         return segint_pkg::coord_type'(-lim);
      end
      return segint_pkg::coord_type'(v);
   endfunction

   function automatic bit strictly_between(longint s, longint e, longint p);
      return (s < e && p > s && p < e) || (s > e && p < s && p > e);
   endfunction

   function automatic segint_pkg::rsp_type predict_crossing(segint_pkg::req_type r);
      longint   x1s, y1s, x1e, y1e, x2s, y2s, x2e, y2e;
      longint   dx1, dy1, dx2, dy2;
      wide_type den;
      wide_type num;
      bit       vert1, vert2, in1, in2;
      segint_pkg::rsp_type res;
      x1s = r.first_start_x;  y1s = r.first_start_y;
      x1e = r.first_end_x;    y1e = r.first_end_y;
      x2s = r.second_start_x; y2s = r.second_start_y;
      x2e = r.second_end_x;   y2e = r.second_end_y;
      dx1 = x1e - x1s; dy1 = y1e - y1s; dx2 = x2e - x2s; dy2 = y2e - y2s;
      vert1 = (dx1 == 0);
      vert2 = (dx2 == 0);
      res = '0;
      res.point_valid = 1'b1;
      if (vert1 && vert2) begin
         res.point_valid = 1'b0;
      end else if (vert1) begin
         res.cross_x = segint_pkg::coord_type'(x1s);
         res.cross_y = clamp_coord(y2s + rounded_quotient(
            wide_type'(dy2) * wide_type'(x1s - x2s), wide_type'(dx2)));
      end else if (vert2) begin
         res.cross_x = segint_pkg::coord_type'(x2s);
         res.cross_y = clamp_coord(y1s + rounded_quotient(
            wide_type'(dy1) * wide_type'(x2s - x1s), wide_type'(dx1)));
      end else begin
         den = wide_type'(dx1) * wide_type'(dy2) - wide_type'(dy1) * wide_type'(dx2);
         if (den == 0) begin
            res.point_valid = 1'b0;
         end else begin
            num = wide_type'(x2s - x1s) * wide_type'(dy2)
                - wide_type'(y2s - y1s) * wide_type'(dx2);
            res.cross_x = clamp_coord(x1s + rounded_quotient(wide_type'(dx1) * num, den));
            res.cross_y = clamp_coord(y1s + rounded_quotient(wide_type'(dy1) * num, den));
         end
      end
      if (res.point_valid) begin
         in1 = vert1 ? strictly_between(y1s, y1e, longint'(res.cross_y))
                     : strictly_between(x1s, x1e, longint'(res.cross_x));
         in2 = vert2 ? strictly_between(y2s, y2e, longint'(res.cross_y))
                     : strictly_between(x2s, x2e, longint'(res.cross_x));
         res.hit = in1 && in2;
      end
      return res;
   endfunction

   function automatic segint_pkg::coord_type near_coord();
      return segint_pkg::coord_type'($signed($urandom_range(0, 32'h0010_0000))
                                     - 32'sh0008_0000);
   endfunction

   function automatic segint_pkg::coord_type grid_coord();
      return segint_pkg::coord_type'(($signed($urandom_range(0, 8)) - 4) <<< 16);
   endfunction

   task automatic add_segments(input segint_pkg::coord_type ax, ay, bx, by, cx, cy, dx, dy);
      segint_pkg::req_type r;
      r.first_start_x = ax;  r.first_start_y = ay;
      r.first_end_x = bx;    r.first_end_y = by;
      r.second_start_x = cx; r.second_start_y = cy;
      r.second_end_x = dx;   r.second_end_y = dy;
      segment_q.push_back(r);
   endtask

   task automatic add_random_pair();
      segint_pkg::coord_type c[8];
      int        mode;
      int        k;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) begin
         c[i] = (mode < 2) ? segint_pkg::coord_type'($urandom)
              : (mode == 9) ? grid_coord() : near_coord();
      end
      case (mode)
         6: begin
            c[2] = c[0];
         end
         7: begin
            k = $signed($urandom_range(0, 6)) - 3;
            c[6] = c[4] + segint_pkg::coord_type'(k) * ((c[2] - c[0]) >>> 2);
            c[7] = c[5] + segint_pkg::coord_type'(k) * ((c[3] - c[1]) >>> 2);
            if (k == 0) begin
               c[6] = c[4];
            end
         end
         8: begin
            c[2] = c[0];
            c[6] = c[4];
         end
         default: begin
         end
      endcase
      if (mode == 3) begin
         c[6] = c[4];
      end
      add_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
   endtask

   function automatic int sender_idle_pct();
      if (sent_count < total_items / 3) begin
         return 29;
      end
      if (sent_count < 2 * total_items / 3) begin
         return 71;
      end
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (sent_count < total_items / 3) begin
         return 71;
      end
      if (sent_count < 2 * total_items / 3) begin
         return 29;
      end
      return 0;
   endfunction

   always @(negedge clock) begin
      logic                next_valid;
      segint_pkg::req_type next_data;
      bit                  hold_off;
      next_valid = req_valid;
      next_data = req_data;
      if (!reset && (!req_valid || req_taken)) begin
         next_valid = 1'b0;
         hold_off = (sent_count == drain_at) && !drained && crossing_q.size() != 0;
         if (sent_count == drain_at && crossing_q.size() == 0) begin
            drained = 1'b1;
         end
         if (segment_q.size() != 0 && !hold_off
             && $urandom_range(0, 99) >= sender_idle_pct()) begin
            next_valid = 1'b1;
            next_data = segment_q.pop_front();
         end
      end
      req_valid <= next_valid;
      req_data <= next_data;
      rsp_stall <= !reset && ($urandom_range(0, 99) < receiver_stall_pct());
   end

   always @(posedge clock) begin
      segint_pkg::rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            crossing_q.push_back(predict_crossing(req_data));
            sent_count = sent_count + 1;
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            recv_count = recv_count + 1;
            if (crossing_q.size() == 0) begin
               $error("Result transfer with no request outstanding");
               error_count = error_count + 1;
            end else begin
               want = crossing_q.pop_front();
               hit_count = hit_count + want.hit;
               parallel_count = parallel_count + !want.point_valid;
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
                  error_count = error_count + 1;
               end
               if (rsp_data.point_valid !== want.point_valid) begin
                  $error("point_valid: expected %0d, got %0d",
                         want.point_valid, rsp_data.point_valid);
                  error_count = error_count + 1;
               end
               if (rsp_data.cross_x !== want.cross_x) begin
                  $error("cross_x: expected %h, got %h", want.cross_x, rsp_data.cross_x);
                  error_count = error_count + 1;
               end
               if (rsp_data.cross_y !== want.cross_y) begin
                  $error("cross_y: expected %h, got %h", want.cross_y, rsp_data.cross_y);
                  error_count = error_count + 1;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding.", crossing_q.size());
            $display("** segment_intersection_2d_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      segint_pkg::coord_type top;
      segint_pkg::coord_type bottom;
      top = segint_pkg::coord_type'({1'b0, {(segint_pkg::COORD_WIDTH - 1){1'b1}}});
      bottom = segint_pkg::coord_type'({1'b1, {(segint_pkg::COORD_WIDTH - 1){1'b0}}});
      // Plain crossing, touching at an endpoint, and a miss outside both segments.
      add_segments(0, 0, 4 << 16, 4 << 16, 0, 4 << 16, 4 << 16, 0);
      add_segments(0, 0, 2 << 16, 2 << 16, 2 << 16, 2 << 16, 4 << 16, 0);
      add_segments(0, 0, 1 << 16, 1 << 16, 5 << 16, 0, 6 << 16, -(1 << 16));
      // Vertical cases and a segment collapsed to a point.
      add_segments(1 << 16, -(3 << 16), 1 << 16, 3 << 16, 0, 0, 4 << 16, 2 << 16);
      add_segments(-(2 << 16), 0, 2 << 16, 1 << 16, 0, 3 << 16, 0, -(3 << 16));
      add_segments(1 << 16, 0, 1 << 16, 5 << 16, 3 << 16, 0, 3 << 16, 5 << 16);
      add_segments(7, 7, 7, 7, 0, 0, 9, 9);
      add_segments(3, 3, 3, 3, 3, 3, 3, 3);
      // Parallel and identical lines.
      add_segments(0, 0, 2 << 16, 1 << 16, 0, 1 << 16, 4 << 16, 3 << 16);
      add_segments(0, 0, 2, 2, 0, 0, 2, 2);
      // Exact halfway rounding, both signs, and a one-third quotient that rounds down.
      add_segments(0, 0, 2, 1, 1, -5, 1, 5);
      add_segments(0, 0, 2, -1, 1, -5, 1, 5);
      add_segments(0, 0, 3, 1, 1, 0, 1, 9);
      // Coordinate extremes and saturation.
      add_segments(bottom, bottom, top, top, bottom, top, top, bottom);
      add_segments(bottom, bottom, top, bottom + 1, top, top, top - 1, bottom);
      add_segments(0, 0, 1, 1, 2, 0, 3, 1 + 1);
      add_segments(top, 0, top, 1, bottom, bottom, bottom + 1, top);
      add_segments(0, top, 1, bottom, 3, top, 4, bottom + 2);
      add_segments(-1, -1, -1, -1, -1, -1, -1, -1);
      add_segments(0, 0, 0, 0, 0, 0, 0, 0);
      add_segments(bottom, top, top, bottom, 0, bottom, 1, top);
      drain_at = segment_q.size() + RANDOM_ITEMS / 2;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_random_pair();
      end
      total_items = segment_q.size();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (segment_q.size() == 0 && !req_valid && crossing_q.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      $display("Checked %0d segment pairs: %0d hits, %0d parallel or both vertical.",
               recv_count, hit_count, parallel_count);
      $display("Sender and receiver idling were swept through three phases with one full drain.");
      if (error_count == 0 && crossing_q.size() == 0) begin
         $display("** segment_intersection_2d_top: PASSED **");
      end else begin
         $display("** segment_intersection_2d_top: FAILED **");
      end
      $finish;
   end

endmodule
